[sv/esctr_pkg.sv]
`default_nettype none
package esctr_pkg;

	localparam int unsigned MAX_DUTY_BITS_DEF = 16;

	localparam logic [1:0] REQ_TICK   = 2'd0;
	localparam logic [1:0] REQ_SET    = 2'd1;
	localparam logic [1:0] REQ_STOP   = 2'd2;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	localparam logic [1:0] MODE_IDLE  = 2'd0;
	localparam logic [1:0] MODE_ACCEL = 2'd1;
	localparam logic [1:0] MODE_RUN   = 2'd2;
	localparam logic [1:0] MODE_DECEL = 2'd3;

	localparam logic [1:0] CFG_MIN_PULSE  = 2'd0;
	localparam logic [1:0] CFG_MAX_PULSE  = 2'd1;
	localparam logic [1:0] CFG_PWM_FREQ   = 2'd2;
	localparam logic [1:0] CFG_DUTY_RES   = 2'd3;

	localparam logic [15:0] MIN_PULSE_RST = 16'd1000;
	localparam logic [15:0] MAX_PULSE_RST = 16'd2000;
	localparam logic [15:0] PWM_FREQ_RST  = 16'd50;
	localparam logic [4:0]  DUTY_RES_RST  = 5'd16;
	localparam logic [15:0] RAMP_LEN_RST  = 16'd1000;

	localparam logic [13:0] FULL_THROTTLE = 14'd10000;
	localparam logic [19:0] USEC_PER_SEC  = 20'd1000000;
	localparam int unsigned DIVISOR_W     = 20;

	// floor(x / 10000) = (x * SPAN_RECIP) >> SPAN_SHIFT for x below 2^30
	localparam logic [29:0] SPAN_RECIP    = 30'd879609303;
	localparam int unsigned SPAN_SHIFT    = 43;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_TICK_END,
		OP_TICK_MUL,
		OP_RAMP,
		OP_SET_NOW,
		OP_STOP_NOW,
		OP_INTERP_TAKE,
		OP_SPAN_MUL,
		OP_SPAN_RECIP,
		OP_PULSE_TAKE,
		OP_PERIOD_TAKE,
		OP_DUTY_MUL,
		OP_DUTY_TAKE,
		OP_OUT_LOAD
	} op_t;

	typedef enum logic [1:0] {
		DIV_INTERP,
		DIV_PERIOD,
		DIV_DUTY
	} div_sel_t;

	typedef struct packed {
		op_t      op;
		logic     div_start;
		div_sel_t div_sel;
	} cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       ramping;
		logic       tick_done;
		logic       set_ramp;
		logic       stop_ramp;
		logic       div_done;
	} status_t;

endpackage
`default_nettype wire

[sv/esctr_div.sv]
`default_nettype none
module esctr_div #(
	parameter int unsigned DW = 32,
	parameter int unsigned VW = 20
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [VW-1:0] divisor,
	output logic               done,
	output logic [DW-1:0]      quotient
);

	localparam int unsigned CW = (DW > 1) ? $clog2(DW) : 1;

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] quo_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dsr_q;
	logic [VW:0]   rem_sh;
	logic          fits;

	assign rem_sh = {rem_q, quo_q[DW-1]};
	assign fits   = rem_sh >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= VW'(rem_sh - {1'b0, dsr_q});
			end else begin
				rem_q <= rem_sh[VW-1:0];
			end
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

[sv/esctr_dp.sv]
`default_nettype none
module esctr_dp #(
	parameter int unsigned MAX_DUTY_BITS = esctr_pkg::MAX_DUTY_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire esctr_pkg::cmd_t   cmd,
	output esctr_pkg::status_t     status,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [15:0]       cfg_data,
	input  wire logic [1:0]        req_type,
	input  wire logic [13:0]       throttle_req,
	input  wire logic              smooth,
	input  wire logic [15:0]       ramp_ms,
	output logic [1:0]             motor_state,
	output logic [13:0]            throttle_now,
	output logic [15:0]            pulse_us,
	output logic [15:0]            duty_value
);

	localparam int unsigned PDW = 16 + MAX_DUTY_BITS;
	localparam int unsigned DW  = (PDW > 31) ? PDW : 31;
	localparam int unsigned VW  = esctr_pkg::DIVISOR_W;

	logic [15:0] min_q, max_q, freq_q;
	logic [4:0]  res_q;

	logic [1:0]  kind_q;
	logic [13:0] req_q;
	logic        smooth_q;
	logic [15:0] len_q;

	logic [1:0]  mode_q;
	logic [15:0] elapsed_q;
	logic [15:0] length_q;
	logic [13:0] start_q;
	logic [13:0] goal_q;
	logic [13:0] thr_q;
	logic [15:0] pulse_q;
	logic [15:0] duty_q;

	logic [13:0]    t_q;
	logic           ovr_q;
	logic [1:0]     ovr_mode_q;
	logic [29:0]    pa_q;
	logic [29:0]    pb_q;
	logic           neg_q;
	logic [15:0]    sq_q;
	logic [15:0]    pw_q;
	logic [VW-1:0]  period_q;
	logic [PDW-1:0] pd_q;

	logic [1:0]  mode_o_q;
	logic [13:0] thr_o_q;
	logic [15:0] pulse_o_q;
	logic [15:0] duty_o_q;

	logic [15:0]              e_next;
	logic [16:0]              span;
	logic [16:0]              mag;
	logic [59:0]              span_prod;
	logic [17:0]              pw_raw;
	logic [15:0]              pw_clamped;
	logic [31:0]              bits_eff;
	logic [MAX_DUTY_BITS-1:0] top;
	logic [DW-1:0]            duty_full;
	logic [1:0]               mode_rule;
	logic [DW-1:0]            dvd;
	logic [VW-1:0]            dsr;
	logic                     div_done;
	logic [DW-1:0]            quot;

	assign e_next = (elapsed_q != 16'hFFFF) ? elapsed_q + 16'd1 : elapsed_q;

	assign span = {1'b0, max_q} - {1'b0, min_q};
	assign mag  = span[16] ? 17'd0 - span : span;

	assign span_prod = 60'(pa_q) * 60'(esctr_pkg::SPAN_RECIP);

	assign pw_raw = neg_q ? {2'b00, min_q} - {2'b00, sq_q}
		: {2'b00, min_q} + {2'b00, sq_q};

	always_comb begin
		if ($signed(pw_raw) < $signed({2'b00, min_q})) begin
			pw_clamped = min_q;
		end else if ($signed(pw_raw) > $signed({2'b00, max_q})) begin
			pw_clamped = max_q;
		end else begin
			pw_clamped = pw_raw[15:0];
		end
	end

	assign bits_eff = ({27'd0, res_q} > 32'(MAX_DUTY_BITS)) ? 32'(MAX_DUTY_BITS)
		: {27'd0, res_q};
	assign top = {MAX_DUTY_BITS{1'b1}} >> (32'(MAX_DUTY_BITS) - bits_eff);
	assign duty_full = (quot > DW'(top)) ? DW'(top) : quot;

	always_comb begin
		mode_rule = mode_q;
		if (t_q != 14'd0 && mode_q == esctr_pkg::MODE_IDLE) begin
			mode_rule = esctr_pkg::MODE_RUN;
		end else if (t_q == 14'd0 && mode_q == esctr_pkg::MODE_RUN) begin
			mode_rule = esctr_pkg::MODE_IDLE;
		end
	end

	always_comb begin
		case (cmd.div_sel)
			esctr_pkg::DIV_INTERP: begin
				dvd = DW'({1'b0, pa_q} + {1'b0, pb_q});
				dsr = VW'(length_q);
			end
			esctr_pkg::DIV_PERIOD: begin
				dvd = DW'(esctr_pkg::USEC_PER_SEC);
				dsr = (freq_q == 16'd0) ? VW'(1) : VW'(freq_q);
			end
			default: begin
				dvd = DW'(pd_q);
				dsr = period_q;
			end
		endcase
	end

	esctr_div #(
		.DW(DW),
		.VW(VW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (dsr),
		.done     (div_done),
		.quotient (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q     <= esctr_pkg::MIN_PULSE_RST;
			max_q     <= esctr_pkg::MAX_PULSE_RST;
			freq_q    <= esctr_pkg::PWM_FREQ_RST;
			res_q     <= esctr_pkg::DUTY_RES_RST;
			mode_q    <= esctr_pkg::MODE_IDLE;
			elapsed_q <= '0;
			length_q  <= esctr_pkg::RAMP_LEN_RST;
			start_q   <= '0;
			goal_q    <= '0;
			thr_q     <= '0;
			pulse_q   <= esctr_pkg::MIN_PULSE_RST;
			duty_q    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					esctr_pkg::CFG_MIN_PULSE: min_q  <= cfg_data;
					esctr_pkg::CFG_MAX_PULSE: max_q  <= cfg_data;
					esctr_pkg::CFG_PWM_FREQ:  freq_q <= cfg_data;
					default:                  res_q  <= cfg_data[4:0];
				endcase
			end
			case (cmd.op)
				esctr_pkg::OP_TICK_END, esctr_pkg::OP_TICK_MUL: begin
					elapsed_q <= e_next;
				end
				esctr_pkg::OP_RAMP: begin
					start_q   <= thr_q;
					goal_q    <= (kind_q == esctr_pkg::REQ_SET) ? req_q : 14'd0;
					length_q  <= len_q;
					elapsed_q <= '0;
					mode_q    <= (kind_q == esctr_pkg::REQ_SET) ? esctr_pkg::MODE_ACCEL
						: esctr_pkg::MODE_DECEL;
				end
				esctr_pkg::OP_DUTY_TAKE: begin
					duty_q  <= duty_full[15:0];
					pulse_q <= pw_q;
					thr_q   <= t_q;
					mode_q  <= ovr_q ? ovr_mode_q : mode_rule;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			esctr_pkg::OP_CAPTURE: begin
				kind_q   <= req_type;
				req_q    <= (throttle_req > esctr_pkg::FULL_THROTTLE)
					? esctr_pkg::FULL_THROTTLE : throttle_req;
				smooth_q <= smooth;
				len_q    <= ramp_ms;
			end
			esctr_pkg::OP_TICK_END: begin
				t_q        <= (mode_q == esctr_pkg::MODE_ACCEL) ? goal_q : 14'd0;
				ovr_q      <= 1'b1;
				ovr_mode_q <= (mode_q == esctr_pkg::MODE_ACCEL) ? esctr_pkg::MODE_RUN
					: esctr_pkg::MODE_IDLE;
			end
			esctr_pkg::OP_TICK_MUL: begin
				pa_q  <= 30'(start_q) * 30'(length_q - e_next);
				pb_q  <= (mode_q == esctr_pkg::MODE_ACCEL) ? 30'(goal_q) * 30'(e_next)
					: 30'd0;
				ovr_q <= 1'b0;
			end
			esctr_pkg::OP_SET_NOW: begin
				t_q   <= req_q;
				ovr_q <= 1'b0;
			end
			esctr_pkg::OP_STOP_NOW: begin
				t_q        <= '0;
				ovr_q      <= 1'b1;
				ovr_mode_q <= esctr_pkg::MODE_IDLE;
			end
			esctr_pkg::OP_INTERP_TAKE: begin
				t_q <= quot[13:0];
			end
			esctr_pkg::OP_SPAN_MUL: begin
				pa_q  <= 30'(t_q) * 30'(mag[15:0]);
				neg_q <= span[16];
			end
			esctr_pkg::OP_SPAN_RECIP: begin
				sq_q <= span_prod[esctr_pkg::SPAN_SHIFT +: 16];
			end
			esctr_pkg::OP_PULSE_TAKE: begin
				pw_q <= pw_clamped;
			end
			esctr_pkg::OP_PERIOD_TAKE: begin
				period_q <= quot[VW-1:0];
			end
			esctr_pkg::OP_DUTY_MUL: begin
				pd_q <= PDW'(pw_q) * PDW'(top);
			end
			esctr_pkg::OP_OUT_LOAD: begin
				mode_o_q  <= mode_q;
				thr_o_q   <= thr_q;
				pulse_o_q <= pulse_q;
				duty_o_q  <= duty_q;
			end
			default: begin
			end
		endcase
	end

	assign status.kind      = kind_q;
	assign status.ramping   = (mode_q == esctr_pkg::MODE_ACCEL)
		|| (mode_q == esctr_pkg::MODE_DECEL);
	assign status.tick_done = e_next >= length_q;
	assign status.set_ramp  = smooth_q && (req_q != thr_q);
	assign status.stop_ramp = smooth_q && (thr_q != 14'd0);
	assign status.div_done  = div_done;

	assign motor_state  = mode_o_q;
	assign throttle_now = thr_o_q;
	assign pulse_us     = pulse_o_q;
	assign duty_value   = duty_o_q;

endmodule
`default_nettype wire

[sv/esctr_ctrl.sv]
`default_nettype none
module esctr_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	output logic                    out_valid,
	input  wire logic               out_stall,
	input  wire esctr_pkg::status_t status,
	output esctr_pkg::cmd_t         cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_IDIV_GO,
		S_IDIV_WAIT,
		S_SPAN,
		S_SRECIP,
		S_PTAKE,
		S_PDIV_GO,
		S_PDIV_WAIT,
		S_DMUL,
		S_DDIV_GO,
		S_DDIV_WAIT,
		S_OUT
	} state_t;

	state_t state_q, state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_nxt     = state_q;
		cmd.op        = esctr_pkg::OP_NONE;
		cmd.div_start = 1'b0;
		cmd.div_sel   = esctr_pkg::DIV_INTERP;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op    = esctr_pkg::OP_CAPTURE;
					state_nxt = S_DECODE;
				end
			end
			S_DECODE: begin
				state_nxt = S_OUT;
				case (status.kind)
					esctr_pkg::REQ_TICK: begin
						if (status.ramping && status.tick_done) begin
							cmd.op    = esctr_pkg::OP_TICK_END;
							state_nxt = S_SPAN;
						end else if (status.ramping) begin
							cmd.op    = esctr_pkg::OP_TICK_MUL;
							state_nxt = S_IDIV_GO;
						end
					end
					esctr_pkg::REQ_SET: begin
						if (status.set_ramp) begin
							cmd.op = esctr_pkg::OP_RAMP;
						end else begin
							cmd.op    = esctr_pkg::OP_SET_NOW;
							state_nxt = S_SPAN;
						end
					end
					esctr_pkg::REQ_STOP: begin
						if (status.stop_ramp) begin
							cmd.op = esctr_pkg::OP_RAMP;
						end else begin
							cmd.op    = esctr_pkg::OP_STOP_NOW;
							state_nxt = S_SPAN;
						end
					end
					default: begin
					end
				endcase
			end
			S_IDIV_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = esctr_pkg::DIV_INTERP;
				state_nxt     = S_IDIV_WAIT;
			end
			S_IDIV_WAIT: begin
				if (status.div_done) begin
					cmd.op    = esctr_pkg::OP_INTERP_TAKE;
					state_nxt = S_SPAN;
				end
			end
			S_SPAN: begin
				cmd.op    = esctr_pkg::OP_SPAN_MUL;
				state_nxt = S_SRECIP;
			end
			S_SRECIP: begin
				cmd.op    = esctr_pkg::OP_SPAN_RECIP;
				state_nxt = S_PTAKE;
			end
			S_PTAKE: begin
				cmd.op    = esctr_pkg::OP_PULSE_TAKE;
				state_nxt = S_PDIV_GO;
			end
			S_PDIV_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = esctr_pkg::DIV_PERIOD;
				state_nxt     = S_PDIV_WAIT;
			end
			S_PDIV_WAIT: begin
				if (status.div_done) begin
					cmd.op    = esctr_pkg::OP_PERIOD_TAKE;
					state_nxt = S_DMUL;
				end
			end
			S_DMUL: begin
				cmd.op    = esctr_pkg::OP_DUTY_MUL;
				state_nxt = S_DDIV_GO;
			end
			S_DDIV_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = esctr_pkg::DIV_DUTY;
				state_nxt     = S_DDIV_WAIT;
			end
			S_DDIV_WAIT: begin
				cmd.div_sel = esctr_pkg::DIV_DUTY;
				if (status.div_done) begin
					cmd.op    = esctr_pkg::OP_DUTY_TAKE;
					state_nxt = S_OUT;
				end
			end
			S_OUT: begin
				if (out_free) begin
					cmd.op    = esctr_pkg::OP_OUT_LOAD;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

[sv/esc_throttle_ramp_pwm.sv]
// From acceptance to out_valid: an idle tick, a ramp start or an unused request goes
// from S_DECODE to S_OUT; a throttle applied at once or a ramp end adds the span,
// pulse, period-divide, duty and duty-divide steps; a ramp tick adds an interpolating
// divide first. DW = max(31, 16+MAX_DUTY_BITS) is the width of the shared bit-serial
// divider; no new request is taken until the result is loaded, and a result held by
// out_stall holds off the next one. Reset (arst_n low, asynchronous): registers to
// default config, mode idle, throttle 0, pulse 1000 us, duty 0, no result pending.
`default_nettype none
module esc_throttle_ramp_pwm #(
	parameter int unsigned MAX_DUTY_BITS = esctr_pkg::MAX_DUTY_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  req_type,
	input  wire logic [13:0] throttle_req,
	input  wire logic        smooth,
	input  wire logic [15:0] ramp_ms,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       motor_state,
	output logic [13:0]      throttle_now,
	output logic [15:0]      pulse_us,
	output logic [15:0]      duty_value,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	esctr_pkg::cmd_t    cmd;
	esctr_pkg::status_t status;

	assign cfg_ready = 1'b1;

	esctr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	esctr_dp #(
		.MAX_DUTY_BITS(MAX_DUTY_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_we       (cfg_valid & cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.req_type     (req_type),
		.throttle_req (throttle_req),
		.smooth       (smooth),
		.ramp_ms      (ramp_ms),
		.motor_state  (motor_state),
		.throttle_now (throttle_now),
		.pulse_us     (pulse_us),
		.duty_value   (duty_value)
	);

endmodule
`default_nettype wire

[tb/tb_esc_throttle_ramp_pwm.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb_esc_throttle_ramp_pwm;

	typedef struct packed {
		logic [1:0]  st;
		logic [13:0] thr;
		logic [15:0] pw;
		logic [15:0] duty;
	} esc_out_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [1:0] req_type;
	logic [13:0] throttle_req;
	logic smooth;
	logic [15:0] ramp_ms;
	logic out_valid;
	logic out_stall;
	logic [1:0] motor_state;
	logic [13:0] throttle_now;
	logic [15:0] pulse_us;
	logic [15:0] duty_value;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;

	esc_throttle_ramp_pwm uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .throttle_req(throttle_req),
		.smooth(smooth), .ramp_ms(ramp_ms),
		.out_valid(out_valid), .out_stall(out_stall),
		.motor_state(motor_state), .throttle_now(throttle_now),
		.pulse_us(pulse_us), .duty_value(duty_value),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// settings and state of the expected-behavior copy
	logic [15:0] set_min, set_max, set_freq;
	logic [4:0] set_res;
	logic [1:0] esc_mode;
	logic [15:0] r_elapsed, r_length;
	logic [13:0] r_start, r_goal, thr_reg;
	logic [15:0] pw_reg, duty_reg;

	esc_out_t expected_q[$];
	int errors = 0;
	int n_items = 0;
	int n_checked = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	longint cycles = 0;

	function automatic void drive_pulse(input longint pw_in);
		longint pw, top, period, d;
		int bits;
		pw = pw_in;
		if (pw < set_min) pw = set_min;
		else if (pw > set_max) pw = set_max;
		bits = (set_res > esctr_pkg::MAX_DUTY_BITS_DEF) ? int'(esctr_pkg::MAX_DUTY_BITS_DEF)
			: int'(set_res);
		top = (64'd1 << bits) - 1;
		period = 1000000 / ((set_freq == 0) ? 1 : set_freq);
		d = (pw * top) / period;
		if (d > top) d = top;
		pw_reg = pw[15:0];
		duty_reg = d[15:0];
	endfunction

	function automatic void apply_throttle(input logic [13:0] t);
		longint span;
		span = longint'(set_max) - longint'(set_min);
		drive_pulse(longint'(set_min) + (longint'(t) * span) / 10000);
		thr_reg = t;
		if (t > 0 && esc_mode == esctr_pkg::MODE_IDLE) esc_mode = esctr_pkg::MODE_RUN;
		else if (t == 0 && esc_mode == esctr_pkg::MODE_RUN) esc_mode = esctr_pkg::MODE_IDLE;
	endfunction

	function automatic void start_ramp(input logic [13:0] goal, input logic [15:0] len,
			input logic [1:0] m);
		r_start = thr_reg;
		r_goal = goal;
		r_length = len;
		r_elapsed = 16'd0;
		esc_mode = m;
	endfunction

	function automatic esc_out_t esc_step(input logic [1:0] kind, input logic [13:0] req_in,
			input logic sm, input logic [15:0] len);
		logic [13:0] req;
		longint num;
		esc_out_t r;
		req = (req_in > esctr_pkg::FULL_THROTTLE) ? esctr_pkg::FULL_THROTTLE : req_in;
		if (kind == esctr_pkg::REQ_TICK) begin
			if (esc_mode == esctr_pkg::MODE_ACCEL || esc_mode == esctr_pkg::MODE_DECEL) begin
				if (r_elapsed != 16'hFFFF) r_elapsed++;
				if (r_elapsed >= r_length) begin
					if (esc_mode == esctr_pkg::MODE_ACCEL) begin
						apply_throttle(r_goal);
						esc_mode = esctr_pkg::MODE_RUN;
					end else begin
						apply_throttle(14'd0);
						esc_mode = esctr_pkg::MODE_IDLE;
					end
				end else begin
					num = longint'(r_start) * (r_length - r_elapsed);
					if (esc_mode == esctr_pkg::MODE_ACCEL) num += longint'(r_goal) * r_elapsed;
					apply_throttle(14'(num / r_length));
				end
			end
		end else if (kind == esctr_pkg::REQ_SET) begin
			if (sm && req != thr_reg) start_ramp(req, len, esctr_pkg::MODE_ACCEL);
			else apply_throttle(req);
		end else if (kind == esctr_pkg::REQ_STOP) begin
			if (sm && thr_reg > 0) start_ramp(14'd0, len, esctr_pkg::MODE_DECEL);
			else begin
				apply_throttle(14'd0);
				esc_mode = esctr_pkg::MODE_IDLE;
			end
		end
		r.st = esc_mode;
		r.thr = thr_reg;
		r.pw = pw_reg;
		r.duty = duty_reg;
		return r;
	endfunction

	task automatic send_req(input logic [1:0] kind, input logic [13:0] req,
			input logic sm, input logic [15:0] len);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		throttle_req <= req;
		smooth <= sm;
		ramp_ms <= len;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_q.push_back(esc_step(kind, req, sm, len));
		n_items++;
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			esctr_pkg::CFG_MIN_PULSE: set_min = val;
			esctr_pkg::CFG_MAX_PULSE: set_max = val;
			esctr_pkg::CFG_PWM_FREQ: set_freq = val;
			default: set_res = val[4:0];
		endcase
	endtask

	task automatic set_config(input logic [15:0] mn, input logic [15:0] mx,
			input logic [15:0] fr, input logic [4:0] rs);
		wait_drain();
		write_reg(esctr_pkg::CFG_MIN_PULSE, mn);
		write_reg(esctr_pkg::CFG_MAX_PULSE, mx);
		write_reg(esctr_pkg::CFG_PWM_FREQ, fr);
		write_reg(esctr_pkg::CFG_DUTY_RES, {11'd0, rs});
		cfg_valid <= 1'b0;
	endtask

	task automatic send_random();
		int p;
		logic [13:0] t;
		logic [15:0] len;
		p = $urandom_range(99);
		t = ($urandom_range(3) == 0) ? 14'($urandom) : 14'($urandom_range(10000));
		len = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(12));
		if (p < 55)
			send_req(esctr_pkg::REQ_TICK, 14'($urandom), 1'($urandom), 16'($urandom));
		else if (p < 80) send_req(esctr_pkg::REQ_SET, t, 1'($urandom), len);
		else if (p < 95) send_req(esctr_pkg::REQ_STOP, 14'($urandom), 1'($urandom), len);
		else send_req(esctr_pkg::REQ_UNUSED, 14'($urandom), 1'($urandom), 16'($urandom));
	endtask

	task automatic test_directed();
		send_req(esctr_pkg::REQ_TICK, 14'd0, 1'b0, 16'd0);
		send_req(esctr_pkg::REQ_SET, 14'h3FFF, 1'b0, 16'd0);
		send_req(esctr_pkg::REQ_SET, 14'd0, 1'b0, 16'd0);
		send_req(esctr_pkg::REQ_SET, 14'd10000, 1'b1, 16'd4);
		repeat (5) send_req(esctr_pkg::REQ_TICK, 14'd0, 1'b0, 16'd0);
		send_req(esctr_pkg::REQ_SET, 14'd2000, 1'b1, 16'd3);
		repeat (3) send_req(esctr_pkg::REQ_TICK, 14'd0, 1'b0, 16'd0);
		send_req(esctr_pkg::REQ_STOP, 14'd0, 1'b1, 16'd3);
		repeat (3) send_req(esctr_pkg::REQ_TICK, 14'd0, 1'b0, 16'd0);
		send_req(esctr_pkg::REQ_SET, 14'd5000, 1'b1, 16'd0);
		send_req(esctr_pkg::REQ_TICK, 14'd0, 1'b0, 16'd0);
		send_req(esctr_pkg::REQ_STOP, 14'h3FFF, 1'b1, 16'hFFFF);
		send_req(esctr_pkg::REQ_TICK, 14'd0, 1'b0, 16'd0);
		send_req(esctr_pkg::REQ_UNUSED, 14'h3FFF, 1'b1, 16'hFFFF);
		send_req(esctr_pkg::REQ_STOP, 14'd0, 1'b0, 16'd0);
		send_req(esctr_pkg::REQ_STOP, 14'd0, 1'b1, 16'd5);
	endtask

	task automatic test_random_phase(input int n, input int idle, input int stall);
		send_idle_pct = idle;
		stall_pct = stall;
		repeat (n) send_random();
	endtask

	task automatic test_config_extremes();
		set_config(16'd1500, 16'd1500, 16'd50, 5'd16);
		test_random_phase(60, 0, 0);
		set_config(16'd2000, 16'd1000, 16'd65535, 5'd1);
		test_random_phase(60, 34, 34);
		set_config(16'd0, 16'd65535, 16'd1, 5'd0);
		test_random_phase(60, 63, 0);
		set_config(16'd65535, 16'd0, 16'd0, 5'd31);
		test_random_phase(60, 0, 63);
		set_config(16'd800, 16'd2200, 16'd400, 5'd12);
		test_random_phase(60, 0, 0);
	endtask

	task automatic test_long_ramp();
		// hold off until the block is fully drained, then sweep one long ramp
		wait_drain();
		send_req(esctr_pkg::REQ_SET, 14'd9999, 1'b1, 16'd300);
		repeat (310) send_req(esctr_pkg::REQ_TICK, 14'd0, 1'b0, 16'd0);
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n) out_stall <= ($urandom_range(99) < stall_pct);
		if (cycles > 3000000) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		esc_out_t got, exp_r;
		if (arst_n && out_valid && !out_stall) begin
			got = {motor_state, throttle_now, pulse_us, duty_value};
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
			end else begin
				exp_r = expected_q.pop_front();
				n_checked++;
				if (got.st !== exp_r.st)
					$display("%0t: motor_state exp %0d got %0d", $time, exp_r.st, got.st);
				if (got.thr !== exp_r.thr)
					$display("%0t: throttle_now exp %0d got %0d", $time, exp_r.thr, got.thr);
				if (got.pw !== exp_r.pw)
					$display("%0t: pulse_us exp %0d got %0d", $time, exp_r.pw, got.pw);
				if (got.duty !== exp_r.duty)
					$display("%0t: duty_value exp %0d got %0d", $time, exp_r.duty, got.duty);
				if (got !== exp_r) errors++;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = esctr_pkg::REQ_TICK;
		throttle_req = 14'd0;
		smooth = 1'b0;
		ramp_ms = 16'd0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = esctr_pkg::CFG_MIN_PULSE;
		cfg_data = 16'd0;
		set_min = esctr_pkg::MIN_PULSE_RST;
		set_max = esctr_pkg::MAX_PULSE_RST;
		set_freq = esctr_pkg::PWM_FREQ_RST;
		set_res = esctr_pkg::DUTY_RES_RST;
		esc_mode = esctr_pkg::MODE_IDLE;
		r_elapsed = 16'd0;
		r_length = esctr_pkg::RAMP_LEN_RST;
		r_start = 14'd0;
		r_goal = 14'd0;
		thr_reg = 14'd0;
		pw_reg = esctr_pkg::MIN_PULSE_RST;
		duty_reg = 16'd0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_phase(150, 0, 0);
		test_random_phase(150, 63, 0);
		test_random_phase(150, 0, 63);
		test_random_phase(150, 34, 34);
		test_config_extremes();
		send_idle_pct = 0;
		stall_pct = 0;
		test_long_ramp();
		wait_drain();
		$display("Sent %0d requests (ticks, set and stop, smooth and immediate) over",
			n_items);
		$display("six pulse/frequency/resolution settings; %0d results compared.", n_checked);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire

[sim.f]
sv/esctr_pkg.sv
sv/esctr_div.sv
sv/esctr_dp.sv
sv/esctr_ctrl.sv
sv/esc_throttle_ramp_pwm.sv
tb/tb_esc_throttle_ramp_pwm.sv
